[design/bcba_pkg.sv]
// Shared types and constants for the first-fit bitmap block allocator.
// Holds field widths, operation codes and the controller/datapath interface structs.
// Used by every allocator module except bcba_ram; depends on nothing.
package bcba_pkg;

    localparam int WORD_BITS      = 32;
    localparam int BIT_W          = 5;
    localparam int MAX_BLOCKS_DEF = 4096;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 16;
    localparam int LEN_W   = 13;
    localparam int FIRST_W = 12;
    localparam int CFG_W   = 13;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 13'd4096;

    // Register index as decoded from paddr[2].
    localparam logic REG_ACTIVE_BLOCKS = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ALLOC = 2'd1,
        OP_MARK  = 2'd2,
        OP_TEST  = 2'd3
    } op_t;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic scan_step;
        logic mark_rd;
        logic mark_wr;
        logic one_rd;
        logic one_upd;
        logic res_fail;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic addr_last;
        logic triv_fail;
        logic hit;
        logic scan_end;
        logic mark_last;
        logic in_range;
    } dp_sts_t;

endpackage

[design/bcba_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// Holds the occupancy map words of the allocator; no dependencies.
module bcba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/bcba_dp.sv]
// Datapath of the bitmap allocator: map RAM, word scanner, run marker and result registers.
// Driven by bcba_ctrl through dp_cmd_t; depends on bcba_pkg and bcba_ram.
module bcba_dp
    import bcba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_sts_t              sts,
    input  op_t                  in_op,
    input  logic [IDX_W-1:0]     in_idx,
    input  logic [LEN_W-1:0]     in_len,
    input  logic [CFG_W-1:0]     active_blocks,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int WORDS = MAX_BLOCKS / WORD_BITS;
    localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = $clog2(MAX_BLOCKS);
    localparam int LW    = (BW + 1 > CFG_W) ? BW + 1 : CFG_W;
    localparam int LWW   = LW - BIT_W;
    localparam int RW    = LEN_W + 1;

    localparam logic [LW-1:0]    MAX_L     = LW'(MAX_BLOCKS);
    localparam logic [IDX_W:0]   MAX_IDX   = (IDX_W + 1)'(MAX_BLOCKS);
    localparam logic [WW-1:0]    LAST_WORD = WW'(WORDS - 1);
    localparam logic [RW-1:0]    RUN_SAT   = {1'b0, {LEN_W{1'b1}}};

    op_t                   op_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [LW-1:0]         limit_reg;
    logic                  in_range_reg;
    logic [WW-1:0]         addr_reg;
    logic [WW-1:0]         pword_reg;
    logic                  dvalid_reg;
    logic [LEN_W-1:0]      run_reg;
    logic [BW-1:0]         start_reg;
    logic [BW-1:0]         end_reg;
    logic                  res_success_reg;
    logic [FIRST_W-1:0]    res_first_reg;
    logic                  res_occ_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    logic [LW-1:0]         act_ext;
    logic [LW-1:0]         limit_in;
    logic                  in_range_in;
    logic [WORD_BITS-1:0]  ram_rdata;
    logic                  ram_we;
    logic [WW-1:0]         ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic                  ram_re;
    logic [WW-1:0]         ram_raddr;

    logic [LWW-1:0]        limit_word;
    logic [BIT_W-1:0]      limit_bit;
    logic [LWW-1:0]        pword_ext;
    logic [WORD_BITS-1:0]  busy_mask;
    logic [WORD_BITS-1:0]  busy;
    logic [BIT_W-1:0]      lb_arr    [WORD_BITS];
    logic                  found_arr [WORD_BITS];
    logic [RW-1:0]         runlen_arr[WORD_BITS];
    logic [WORD_BITS-1:0]  hit_vec;
    logic [BIT_W-1:0]      hit_pos;
    logic                  any_hit;
    logic                  eval;
    logic [LW-1:0]         g_end;
    logic [LW-1:0]         start_l;
    logic [BW-1:0]         start_next;
    logic [BW-1:0]         end_next;
    logic [LEN_W-1:0]      run_next;
    logic [WW-1:0]         last_scan_word;

    logic [WW-1:0]         start_word;
    logic [WW-1:0]         end_word;
    logic [BIT_W-1:0]      mark_lo;
    logic [BIT_W-1:0]      mark_hi;
    logic [WORD_BITS-1:0]  mark_mask;
    logic [WW-1:0]         idx_word;
    logic [BIT_W-1:0]      idx_bit;

    assign act_ext     = LW'(active_blocks);
    assign limit_in    = (act_ext > MAX_L) ? MAX_L : act_ext;
    assign in_range_in = {1'b0, in_idx} < MAX_IDX;

    assign idx_word   = idx_reg[BW-1:BIT_W];
    assign idx_bit    = idx_reg[BIT_W-1:0];
    assign start_word = start_reg[BW-1:BIT_W];
    assign end_word   = end_reg[BW-1:BIT_W];

    // Blocks at or beyond the search limit read as busy.
    assign limit_word     = limit_reg[LW-1:BIT_W];
    assign limit_bit      = limit_reg[BIT_W-1:0];
    assign pword_ext      = LWW'(pword_reg);
    assign last_scan_word = WW'((limit_reg - LW'(1)) >> BIT_W);

    always_comb begin
        if (pword_ext < limit_word) begin
            busy_mask = '0;
        end else if (pword_ext == limit_word) begin
            busy_mask = {WORD_BITS{1'b1}} << limit_bit;
        end else begin
            busy_mask = {WORD_BITS{1'b1}};
        end
    end

    assign busy = ram_rdata | busy_mask;

    // Length of the free run ending at each bit of the word, counting the carried run.
    always_comb begin
        for (int k = 0; k < WORD_BITS; k++) begin
            lb_arr[k]    = '0;
            found_arr[k] = 1'b0;
            for (int j = 0; j <= k; j++) begin
                if (busy[j]) begin
                    lb_arr[k]    = BIT_W'(j);
                    found_arr[k] = 1'b1;
                end
            end
            if (busy[k]) begin
                runlen_arr[k] = '0;
            end else if (found_arr[k]) begin
                runlen_arr[k] = RW'(k) - RW'(lb_arr[k]);
            end else begin
                runlen_arr[k] = RW'(run_reg) + RW'(k + 1);
            end
            hit_vec[k] = !busy[k] && (runlen_arr[k] >= RW'(len_reg));
        end
    end

    always_comb begin
        hit_pos = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (hit_vec[k]) begin
                hit_pos = BIT_W'(k);
            end
        end
    end

    assign any_hit    = |hit_vec;
    assign eval       = dvalid_reg && cmd.scan_step;
    assign g_end      = (LW'(pword_reg) << BIT_W) | LW'(hit_pos);
    assign start_l    = g_end + LW'(1) - LW'(len_reg);
    assign start_next = start_l[BW-1:0];
    assign end_next   = g_end[BW-1:0];
    assign run_next   = (runlen_arr[WORD_BITS-1] > RUN_SAT) ? RUN_SAT[LEN_W-1:0]
                                                            : runlen_arr[WORD_BITS-1][LEN_W-1:0];

    assign mark_lo   = (addr_reg == start_word) ? start_reg[BIT_W-1:0] : '0;
    assign mark_hi   = (addr_reg == end_word) ? end_reg[BIT_W-1:0] : {BIT_W{1'b1}};
    assign mark_mask = ({WORD_BITS{1'b1}} << mark_lo)
                     & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - mark_hi));

    assign ram_we    = cmd.clr_step || cmd.mark_wr || (cmd.one_upd && op_reg == OP_MARK);
    assign ram_waddr = cmd.one_upd ? idx_word : addr_reg;
    assign ram_re    = cmd.scan_step || cmd.mark_rd || cmd.one_rd;
    assign ram_raddr = cmd.one_rd ? idx_word : addr_reg;

    always_comb begin
        if (cmd.clr_step) begin
            ram_wdata = '0;
        end else if (cmd.mark_wr) begin
            ram_wdata = ram_rdata | mark_mask;
        end else begin
            ram_wdata = ram_rdata | (WORD_BITS'(1) << idx_bit);
        end
    end

    bcba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_map (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg   <= '0;
            dvalid_reg <= 1'b0;
        end else begin
            dvalid_reg <= cmd.scan_step;
            if (cmd.load) begin
                addr_reg <= '0;
            end
            if (cmd.clr_step || cmd.scan_step || cmd.mark_wr) begin
                addr_reg <= (addr_reg == LAST_WORD) ? (cmd.clr_step ? '0 : addr_reg)
                                                    : addr_reg + WW'(1);
            end
            if (eval && any_hit) begin
                addr_reg <= start_next[BW-1:BIT_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg          <= in_op;
            idx_reg         <= in_idx;
            len_reg         <= in_len;
            limit_reg       <= limit_in;
            in_range_reg    <= in_range_in;
            run_reg         <= '0;
            res_success_reg <= 1'b1;
            res_first_reg   <= '0;
            res_occ_reg     <= (in_op == OP_TEST) && !in_range_in;
        end
        if (cmd.scan_step) begin
            pword_reg <= addr_reg;
        end
        if (eval) begin
            run_reg <= run_next;
            if (any_hit) begin
                start_reg     <= start_next;
                end_reg       <= end_next;
                res_first_reg <= FIRST_W'(start_next);
            end
        end
        if (cmd.res_fail) begin
            res_success_reg <= 1'b0;
        end
        if (cmd.one_upd && op_reg == OP_TEST) begin
            res_occ_reg <= ram_rdata[idx_bit];
        end
        if (cmd.out_load) begin
            m_tdata_reg <= M_TDATA_W'({res_occ_reg, res_first_reg, res_success_reg});
        end
    end

    assign m_tdata = m_tdata_reg;

    assign sts.addr_last = addr_reg == LAST_WORD;
    assign sts.triv_fail = (len_reg == '0) || (limit_reg == '0);
    assign sts.hit       = eval && any_hit;
    assign sts.scan_end  = eval && !any_hit && (pword_reg == last_scan_word);
    assign sts.mark_last = addr_reg == end_word;
    assign sts.in_range  = in_range_reg;

endmodule

[design/bcba_ctrl.sv]
// Controller state machine of the bitmap allocator: sequences clear, scan, mark and test.
// Issues dp_cmd_t to bcba_dp and owns both channel handshakes; depends on bcba_pkg.
module bcba_ctrl
    import bcba_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  op_t     in_op,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [8:0] {
        ST_INIT = 9'b000000001,
        ST_IDLE = 9'b000000010,
        ST_CLR  = 9'b000000100,
        ST_SCAN = 9'b000001000,
        ST_MRD  = 9'b000010000,
        ST_MWR  = 9'b000100000,
        ST_ORD  = 9'b001000000,
        ST_OUPD = 9'b010000000,
        ST_DONE = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   out_free;

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT: begin
                cmd.clr_step = 1'b1;
                if (sts.addr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    case (in_op)
                        OP_CLEAR: state_next = ST_CLR;
                        OP_ALLOC: state_next = ST_SCAN;
                        default:  state_next = ST_ORD;
                    endcase
                end
            end
            ST_CLR: begin
                cmd.clr_step = 1'b1;
                if (sts.addr_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (sts.triv_fail) begin
                    cmd.res_fail = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    cmd.scan_step = 1'b1;
                    if (sts.hit) begin
                        state_next = ST_MRD;
                    end else if (sts.scan_end) begin
                        cmd.res_fail = 1'b1;
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_MRD: begin
                cmd.mark_rd = 1'b1;
                state_next  = ST_MWR;
            end
            ST_MWR: begin
                cmd.mark_wr = 1'b1;
                state_next  = sts.mark_last ? ST_DONE : ST_MRD;
            end
            ST_ORD: begin
                cmd.one_rd = 1'b1;
                state_next = sts.in_range ? ST_OUPD : ST_DONE;
            end
            ST_OUPD: begin
                cmd.one_upd = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

[design/bitmap_contiguous_block_allocator.sv]
// Top level of the first-fit bitmap block allocator with its APB register.
// Depends on bcba_pkg, bcba_ctrl and bcba_dp (which holds bcba_ram).
//
// Usage: each word on the s_ channel carries one operation (clear all, allocate a run,
// mark a block, test a block) and produces exactly one result word on the m_ channel.
// The block works on one word at a time: s_tready is high only while it is idle.
// A finished result sits in an output register, so the next word is taken while that
// result still waits for m_tready; a stalled receiver only holds up the word after it.
// Operation steps, with W = MAX_BLOCKS/32 map words:
//   clear writes zero to all W map words. Mark and test read the word holding the index,
//   then set or sample its bit; an index past capacity skips that second step.
//   Allocate scans the map one 32-bit word per cycle from the map RAM's read port (at
//   most W words), then read-modify-writes each word the found run touches; it fails
//   after a scan that finds no run, and without a scan on zero length or no searchable blocks.
// After reset the map is cleared by a pass over all W words, one word a cycle, during
// which s_tready stays low; the active_blocks register is writable at any time.
// The active_blocks register sits at byte address 0 and resets to 4096.
module bitmap_contiguous_block_allocator
    import bcba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // op[1:0], block_index[17:2], run_length[30:18]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // success[0], run_start[12:1], occupied[13]
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    logic [CFG_W-1:0] active_blocks_reg;
    op_t              in_op;
    logic [IDX_W-1:0] in_idx;
    logic [LEN_W-1:0] in_len;
    dp_cmd_t          cmd;
    dp_sts_t          sts;

    assign in_op  = op_t'(s_tdata[OP_W-1:0]);
    assign in_idx = s_tdata[OP_W+IDX_W-1:OP_W];
    assign in_len = s_tdata[OP_W+IDX_W+LEN_W-1:OP_W+IDX_W];

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ACTIVE_BLOCKS) ? APB_DW'(active_blocks_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_blocks_reg <= ACTIVE_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_ACTIVE_BLOCKS) begin
            active_blocks_reg <= pwdata[CFG_W-1:0];
        end
    end

    bcba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_op    (in_op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bcba_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .in_op         (in_op),
        .in_idx        (in_idx),
        .in_len        (in_len),
        .active_blocks (active_blocks_reg),
        .m_tdata       (m_tdata)
    );

endmodule

[design/bcba_checker.sv]
// Port-level checker for the bitmap allocator, bound to the top level.
// Depends on bcba_pkg and on the ports of bitmap_contiguous_block_allocator.
module bcba_checker
    import bcba_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // The block comes out of reset busy with its clearing pass and no result pending.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid && !s_tready)
        else $error("reset did not leave the block busy and the result channel empty");

    // One word at a time: taking a word closes the input until its result is made.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input stayed open after a word was taken");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed or vanished");

    // A failed allocation reports first block zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[0] || m_tdata[12:1] == 12'd0)
        else $error("failed result carries a nonzero first block");

    // Only a test reports occupied, and a test always succeeds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[13] |-> m_tdata[0])
        else $error("occupied flag set on an unsuccessful result");

endmodule

bind bitmap_contiguous_block_allocator bcba_checker u_bcba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
